/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// plain property, sampled on the rising edge, off during reset
`define ASSERT_ON_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ON_CLK(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/gtw_pkg.sv */
// ----------------------------------------------------------------------------
// gtw_pkg
// Types, codes and constants shared by the glyph tile word writer.
// ----------------------------------------------------------------------------
package gtw_pkg;

  localparam int TILE_AXIS_W = 10;
  localparam int TILE_NUM_W  = 2 * TILE_AXIS_W;
  localparam int OFFSET_W    = 25;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = TILE_AXIS_W;

  localparam logic [31:0] NIBBLE_LSBS = 32'h1111_1111;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // result status codes
  localparam logic [2:0] ST_WRITTEN   = 3'd0;
  localparam logic [2:0] ST_ABSENT    = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_UNALIGNED = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  typedef struct packed {
    logic [31:0] row_word;
    logic [4:0]  word_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  glyph_cols;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
  } in_item_t;

  typedef struct packed {
    logic                write_enable;
    logic [OFFSET_W-1:0] write_offset;
    logic [31:0]         write_data;
    logic [2:0]          status;
    logic [1:0]          returned_width;
  } out_item_t;

  // after decode
  typedef struct packed {
    logic                   we;
    logic [2:0]             status;
    logic [1:0]             ret_width;
    logic [TILE_AXIS_W-1:0] qx;
    logic [TILE_AXIS_W-1:0] qy;
    logic [2:0]             row;
    logic [31:0]            nz;
    logic [31:0]            hi;
    logic [31:0]            rep;
    logic [4:0]             delta;
  } dec_stage_t;

  // after multiply
  typedef struct packed {
    logic                   we;
    logic [2:0]             status;
    logic [1:0]             ret_width;
    logic [TILE_AXIS_W-1:0] qx;
    logic [2:0]             row;
    logic [31:0]            prod;
    logic [31:0]            base;
    logic [TILE_NUM_W-1:0]  row_tiles;
  } mul_stage_t;

endpackage

/* rtl/core/gtw_decode.sv */
// ----------------------------------------------------------------------------
// gtw_decode
// First stage: glyph and bounds checks, quadrant tile, nibble masks.
// ----------------------------------------------------------------------------
module gtw_decode (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [gtw_pkg::TILE_AXIS_W-1:0]     width_tiles,
  input  logic [gtw_pkg::TILE_AXIS_W-1:0]     height_tiles,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gtw_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gtw_pkg::dec_stage_t                 out_stage
);
  import gtw_pkg::*;

  logic [12:0] tx;
  logic [12:0] ty;
  logic        cols_ok;
  logic        outside;
  logic        aligned;
  logic        right;
  logic        below;
  logic        has_right;
  logic        has_below;
  logic [31:0] hi;
  dec_stage_t  stage_next;

  assign tx    = in_item.pos_x[15:3];
  assign ty    = in_item.pos_y[15:3];
  assign right = in_item.word_index[3];
  assign below = in_item.word_index[4];

  always_comb begin
    cols_ok   = (in_item.glyph_cols == 8'd1) || (in_item.glyph_cols == 8'd2);
    outside   = (tx >= 13'(width_tiles)) || (ty >= 13'(height_tiles));
    aligned   = (in_item.pos_x[2:0] == 3'd0) && (in_item.pos_y[2:0] == 3'd0);
    has_right = ((14'(tx) + 14'd1) < 14'(width_tiles)) && (in_item.glyph_cols == 8'd2);
    has_below = (14'(ty) + 14'd1) < 14'(height_tiles);
    hi        = (in_item.row_word >> 1) & NIBBLE_LSBS;

    stage_next           = '0;
    stage_next.ret_width = cols_ok ? in_item.glyph_cols[1:0] : 2'd0;
    if (!cols_ok) begin
      stage_next.status = ST_INVALID;
    end else if (outside) begin
      stage_next.status = ST_OUTSIDE;
    end else if (!aligned) begin
      stage_next.status = ST_UNALIGNED;
    end else if ((right && !has_right) || (below && !has_below)) begin
      stage_next.status = ST_ABSENT;
    end else begin
      stage_next.status = ST_WRITTEN;
      stage_next.we     = 1'b1;
    end
    // tile coordinates fit the axis width whenever the write goes ahead
    stage_next.qx    = tx[TILE_AXIS_W-1:0] + TILE_AXIS_W'(right);
    stage_next.qy    = ty[TILE_AXIS_W-1:0] + TILE_AXIS_W'(below);
    stage_next.row   = in_item.word_index[2:0];
    stage_next.hi    = hi;
    stage_next.nz    = (in_item.row_word & NIBBLE_LSBS) | hi;
    stage_next.rep   = {8{in_item.fg_color}};
    stage_next.delta = {1'b0, in_item.bg_color} - {1'b0, in_item.fg_color};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_stage <= stage_next;
    end
  end

endmodule

/* rtl/core/gtw_mult.sv */
// ----------------------------------------------------------------------------
// gtw_mult
// Second stage: colour delta product and tile row base product.
// ----------------------------------------------------------------------------
module gtw_mult (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [gtw_pkg::TILE_AXIS_W-1:0]     width_tiles,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gtw_pkg::dec_stage_t                 in_stage,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gtw_pkg::mul_stage_t                 out_stage
);
  import gtw_pkg::*;

  logic [31:0] delta_ext;
  mul_stage_t  stage_next;

  // delta wraps modulo 2^32, so sign-extend the 5-bit difference
  assign delta_ext = {{27{in_stage.delta[4]}}, in_stage.delta};

  always_comb begin
    stage_next.we        = in_stage.we;
    stage_next.status    = in_stage.status;
    stage_next.ret_width = in_stage.ret_width;
    stage_next.qx        = in_stage.qx;
    stage_next.row       = in_stage.row;
    stage_next.prod      = in_stage.nz * delta_ext;
    stage_next.base      = in_stage.rep + in_stage.hi;
    stage_next.row_tiles = TILE_NUM_W'(width_tiles) * TILE_NUM_W'(in_stage.qy);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_stage <= stage_next;
    end
  end

endmodule

/* rtl/core/gtw_assemble.sv */
// ----------------------------------------------------------------------------
// gtw_assemble
// Last stage: byte offset and coloured word, held in the output register.
// ----------------------------------------------------------------------------
module gtw_assemble (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gtw_pkg::mul_stage_t  in_stage,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gtw_pkg::out_item_t   out_item
);
  import gtw_pkg::*;

  logic [TILE_NUM_W-1:0] tile;
  out_item_t             item_next;

  assign tile = in_stage.row_tiles + TILE_NUM_W'(in_stage.qx);

  always_comb begin
    item_next                = '0;
    item_next.status         = in_stage.status;
    item_next.returned_width = in_stage.ret_width;
    // drop offset and data when nothing is written
    if (in_stage.we) begin
      item_next.write_enable = 1'b1;
      item_next.write_offset = {tile, 5'd0} + OFFSET_W'({in_stage.row, 2'b00});
      item_next.write_data   = in_stage.base + in_stage.prod;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

/* rtl/core/glyph_tile_word_writer.sv */
// ----------------------------------------------------------------------------
// glyph_tile_word_writer
// Maps one 4bpp glyph row word to one coloured tile-buffer write.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_item carries one glyph word with its
//   index, pixel position, glyph width and palette pair. Output channel
//   out_valid/out_ready/out_item returns one result per item: write enable,
//   byte offset, coloured data, status and returned width.
//   Buffer size is set through cfg_write/cfg_index/cfg_data (index 0 width,
//   index 1 height, in tiles); write it only while no item is in flight.
//   Each item passes through the decode, multiply and assemble registers in
//   that order. Throughput is one item per cycle while out_ready is high, set by the
//   three-stage decode / multiply / assemble pipeline.
//   Reset clears both size registers to zero (every position then reports
//   out of bounds unless the glyph width is invalid) and empties the pipeline.
//   When out_ready is low, the output register holds its item and each stage
//   fills in turn; in_ready drops only once all three stages are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glyph_tile_word_writer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gtw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gtw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gtw_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gtw_pkg::out_item_t                out_item
);
  import gtw_pkg::*;

  logic [TILE_AXIS_W-1:0] width_tiles;
  logic [TILE_AXIS_W-1:0] height_tiles;

  logic       dec_valid;
  logic       dec_ready;
  dec_stage_t dec_stage;
  logic       mul_valid;
  logic       mul_ready;
  mul_stage_t mul_stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_tiles  <= '0;
      height_tiles <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  width_tiles  <= cfg_data;
        REG_HEIGHT: height_tiles <= cfg_data;
        default: ;
      endcase
    end
  end

  gtw_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .width_tiles  (width_tiles),
    .height_tiles (height_tiles),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (dec_valid),
    .out_ready    (dec_ready),
    .out_stage    (dec_stage)
  );

  gtw_mult u_mult (
    .clk         (clk),
    .rst         (rst),
    .width_tiles (width_tiles),
    .in_valid    (dec_valid),
    .in_ready    (dec_ready),
    .in_stage    (dec_stage),
    .out_valid   (mul_valid),
    .out_ready   (mul_ready),
    .out_stage   (mul_stage)
  );

  gtw_assemble u_assemble (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_stage  (mul_stage),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  `ASSERT_IMPLIES(a_we_matches_status, clk, rst, out_valid,
    out_item.write_enable == (out_item.status == ST_WRITTEN),
    "write enable disagrees with status")
  `ASSERT_IMPLIES(a_no_write_zero, clk, rst, out_valid && !out_item.write_enable,
    (out_item.write_offset == '0) && (out_item.write_data == '0),
    "suppressed write carries nonzero offset or data")
  `ASSERT_IMPLIES(a_width_vs_status, clk, rst, out_valid,
    (out_item.status == ST_INVALID) ? (out_item.returned_width == 2'd0) :
    ((out_item.returned_width == 2'd1) || (out_item.returned_width == 2'd2)),
    "returned width inconsistent with status")
  `ASSERT_NEXT(a_mid_stage_holds, clk, rst, mul_valid && !mul_ready,
    mul_valid && $stable(mul_stage),
    "stalled multiply stage lost or changed its item")

endmodule
